/* sv/psoc_pkg.sv */
// shared types, widths and constants for the pressure second-order compensation core
// no dependencies; imported by every module of the core
package psoc_pkg;

  localparam int unsigned RawW   = 24;  // raw conversion width
  localparam int unsigned CoeffW = 16;  // calibration word width
  localparam int unsigned OutW   = 32;  // result width

  localparam int unsigned DtW   = 26;  // temperature difference
  localparam int unsigned ProdW = 43;  // dT times a calibration word
  localparam int unsigned DW    = 18;  // first-order temp minus reference
  localparam int unsigned EW    = 19;  // first-order temp minus low band edge
  localparam int unsigned OffW  = 36;  // first-order offset
  localparam int unsigned SensW = 35;  // first-order sensitivity
  localparam int unsigned SqW   = 35;  // squares of the band distances
  localparam int unsigned CorrW = 39;  // second-order corrections
  localparam int unsigned OftW  = 41;  // corrected offset
  localparam int unsigned SntW  = 40;  // corrected sensitivity
  localparam int unsigned LoW   = 20;  // low slice of sensitivity for the split product
  localparam int unsigned LoPW  = 44;  // low partial product
  localparam int unsigned HiPW  = 45;  // high partial product
  localparam int unsigned AccW  = 64;  // full sensitivity times raw pressure
  localparam int unsigned XW    = 43;  // scaled product minus offset

  localparam int unsigned ShiftTemp = 23;
  localparam int unsigned ShiftOff  = 16;
  localparam int unsigned ShiftSens = 15;
  localparam int unsigned ShiftC4   = 7;
  localparam int unsigned ShiftC3   = 8;
  localparam int unsigned ShiftC5   = 8;
  localparam int unsigned ShiftMul  = 21;
  localparam int unsigned ShiftP    = 13;

  // distance from the 20 C reference down to the -15 C band edge, in 0.01 C
  localparam int TempBandOfs = 3500;

  // reciprocal of ten, exact for any 32-bit unsigned dividend
  localparam logic [31:0] Div10Magic = 32'hCCCC_CCCD;
  localparam int unsigned Div10Shift = 35;

  // calibration register indexes on the write port
  typedef enum logic [2:0] {
    CfgC1 = 3'd0,
    CfgC2 = 3'd1,
    CfgC3 = 3'd2,
    CfgC4 = 3'd3,
    CfgC5 = 3'd4,
    CfgC6 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoeffW-1:0] c1;
    logic [CoeffW-1:0] c2;
    logic [CoeffW-1:0] c3;
    logic [CoeffW-1:0] c4;
    logic [CoeffW-1:0] c5;
    logic [CoeffW-1:0] c6;
  } coeff_t;

  // first-order results
  typedef struct packed {
    logic signed [DW-1:0]    d;
    logic signed [OffW-1:0]  off1;
    logic signed [SensW-1:0] sens1;
    logic [RawW-1:0]         d1;
  } fo_t;

  // corrected offset and sensitivity
  typedef struct packed {
    logic signed [OftW-1:0] offt;
    logic signed [SntW-1:0] senst;
    logic [RawW-1:0]        d1;
  } so_t;

endpackage

/* sv/psoc_first_order.sv */
// first-order section: dT, temperature distance, offset and sensitivity, three stages
// depends on psoc_pkg
module psoc_first_order import psoc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  coeff_t          coeff_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [RawW-1:0] raw_pressure_i,
  input  logic [RawW-1:0] raw_temperature_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fo_t             fo_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2] = !vld_q[2] || !out_stall_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 0: dT
  logic signed [DtW-1:0] dt_d, dt_q;
  logic [RawW-1:0]       d1_s0_q, d1_s1_q;
  assign dt_d = $signed({2'b00, raw_temperature_i})
              - $signed({2'b00, coeff_i.c5, {ShiftC5{1'b0}}});

  // stage 1: products with dT
  logic signed [ProdW-1:0] pt_d, po_d, ps_d, pt_q, po_q, ps_q;
  assign pt_d = ProdW'(dt_q) * ProdW'($signed({1'b0, coeff_i.c6}));
  assign po_d = ProdW'(dt_q) * ProdW'($signed({1'b0, coeff_i.c4}));
  assign ps_d = ProdW'(dt_q) * ProdW'($signed({1'b0, coeff_i.c3}));

  // stage 2: scale and add the base terms
  fo_t fo_d, fo_q;
  always_comb begin
    fo_d.d     = DW'(pt_q >>> ShiftTemp);
    fo_d.off1  = OffW'($signed({1'b0, coeff_i.c2, {ShiftOff{1'b0}}}))
               + OffW'(po_q >>> ShiftC4);
    fo_d.sens1 = SensW'($signed({1'b0, coeff_i.c1, {ShiftSens{1'b0}}}))
               + SensW'(ps_q >>> ShiftC3);
    fo_d.d1    = d1_s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dt_q    <= dt_d;
      d1_s0_q <= raw_pressure_i;
    end
    if (adv[1]) begin
      pt_q    <= pt_d;
      po_q    <= po_d;
      ps_q    <= ps_d;
      d1_s1_q <= d1_s0_q;
    end
    if (adv[2]) begin
      fo_q <= fo_d;
    end
  end

  assign fo_o = fo_q;

endmodule

/* sv/psoc_second_order.sv */
// second-order section: band squares, corrections, corrected offset and sensitivity
// depends on psoc_pkg
module psoc_second_order import psoc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  fo_t  fo_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output so_t  so_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2] = !vld_q[2] || !out_stall_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 0: squares and band flags
  logic signed [EW-1:0]     e;
  logic signed [2*SqW-1:0]  sq_full, ee_full;
  logic [SqW-1:0]           sq_q, ee_q;
  logic                     below_ref_q, below_low_q;
  logic signed [OffW-1:0]   off1_s0_q, off1_s1_q;
  logic signed [SensW-1:0]  sens1_s0_q, sens1_s1_q;
  logic [RawW-1:0]          d1_s0_q, d1_s1_q;

  assign e       = EW'(fo_i.d) + EW'(TempBandOfs);
  assign sq_full = (2*SqW)'(fo_i.d) * (2*SqW)'(fo_i.d);
  assign ee_full = (2*SqW)'(e) * (2*SqW)'(e);

  // stage 1: corrections
  logic [CorrW-1:0] sq_w, ee_w, sq3, sq5, ee7, ee4;
  logic [CorrW-1:0] off2_d, sens2_d, off2_q, sens2_q;
  always_comb begin
    sq_w = CorrW'(sq_q);
    ee_w = CorrW'(ee_q);
    sq3  = (sq_w << 1) + sq_w;
    sq5  = (sq_w << 2) + sq_w;
    ee7  = (ee_w << 3) - ee_w;
    ee4  = ee_w << 2;
    if (below_ref_q) begin
      off2_d  = (sq3 >> 1) + (below_low_q ? ee7 : '0);
      sens2_d = (sq5 >> 3) + (below_low_q ? ee4 : '0);
    end else begin
      off2_d  = sq_w >> 4;
      sens2_d = '0;
    end
  end

  // stage 2: subtract corrections
  so_t so_d, so_q;
  always_comb begin
    so_d.offt  = OftW'(off1_s1_q) - OftW'($signed({1'b0, off2_q}));
    so_d.senst = SntW'(sens1_s1_q) - SntW'($signed({1'b0, sens2_q}));
    so_d.d1    = d1_s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sq_q        <= sq_full[SqW-1:0];
      ee_q        <= ee_full[SqW-1:0];
      below_ref_q <= fo_i.d[DW-1];
      below_low_q <= e[EW-1];
      off1_s0_q   <= fo_i.off1;
      sens1_s0_q  <= fo_i.sens1;
      d1_s0_q     <= fo_i.d1;
    end
    if (adv[1]) begin
      off2_q     <= off2_d;
      sens2_q    <= sens2_d;
      off1_s1_q  <= off1_s0_q;
      sens1_s1_q <= sens1_s0_q;
      d1_s1_q    <= d1_s0_q;
    end
    if (adv[2]) begin
      so_q <= so_d;
    end
  end

  assign so_o = so_q;

endmodule

/* sv/psoc_pressure.sv */
// pressure section: split sensitivity product, accumulate, subtract offset and scale
// depends on psoc_pkg
module psoc_pressure import psoc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  so_t                    so_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] p_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2] = !vld_q[2] || !out_stall_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 0: two partial products, low slice unsigned and high slice signed
  logic [LoW-1:0]           lo;
  logic signed [SntW-LoW-1:0] hi;
  logic [LoPW-1:0]          lo_p_d, lo_p_q;
  logic signed [HiPW-1:0]   hi_p_d, hi_p_q;
  logic signed [OftW-1:0]   offt_s0_q, offt_s1_q;

  assign lo     = so_i.senst[LoW-1:0];
  assign hi     = so_i.senst[SntW-1:LoW];
  assign lo_p_d = LoPW'(lo) * LoPW'(so_i.d1);
  assign hi_p_d = HiPW'(hi) * HiPW'($signed({1'b0, so_i.d1}));

  // stage 1: recombine
  logic signed [AccW-1:0] acc_d, acc_q;
  assign acc_d = (AccW'(hi_p_q) <<< LoW) + AccW'($signed({1'b0, lo_p_q}));

  // stage 2: scale, subtract offset, scale again
  logic signed [XW-1:0]   x;
  logic signed [OutW-1:0] p_d, p_q;
  assign x   = XW'(acc_q >>> ShiftMul) - XW'(offt_s1_q);
  assign p_d = OutW'(x >>> ShiftP);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lo_p_q    <= lo_p_d;
      hi_p_q    <= hi_p_d;
      offt_s0_q <= so_i.offt;
    end
    if (adv[1]) begin
      acc_q     <= acc_d;
      offt_s1_q <= offt_s0_q;
    end
    if (adv[2]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* sv/psoc_div10.sv */
// divide by ten truncating toward zero: magnitude, reciprocal multiply, sign restore
// depends on psoc_pkg
module psoc_div10 import psoc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [OutW-1:0] p_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] q_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;

  assign adv[2] = !vld_q[2] || !out_stall_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 0: magnitude and sign
  logic [OutW-1:0] mag_d, mag_q;
  logic            neg_s0_q, neg_s1_q;
  assign mag_d = p_i[OutW-1] ? (~p_i + OutW'(1)) : p_i;

  // stage 1: reciprocal multiply
  logic [2*OutW-1:0] recip;
  logic [OutW-1:0]   qm_q;
  assign recip = (2*OutW)'(mag_q) * (2*OutW)'(Div10Magic);

  // stage 2: restore sign
  logic signed [OutW-1:0] q_d, q_q;
  assign q_d = neg_s1_q ? $signed(~qm_q + OutW'(1)) : $signed(qm_q);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      mag_q    <= mag_d;
      neg_s0_q <= p_i[OutW-1];
    end
    if (adv[1]) begin
      qm_q     <= OutW'(recip >> Div10Shift);
      neg_s1_q <= neg_s0_q;
    end
    if (adv[2]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* sv/pressure_second_order_compensation_core.sv */
// four three-stage sections in series; the last stage is the output register
// throughput: one transaction per cycle while the output is not stalled
// each stage advances when its successor has room, so bubbles close up under a stall
// reset: calibration words clear to zero and every stage valid bit clears
// datapath registers carry no reset
// depends on psoc_pkg, psoc_first_order, psoc_second_order, psoc_pressure, psoc_div10
module pressure_second_order_compensation_core import psoc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // calibration write port
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [CoeffW-1:0]      cfg_data_i,
  // conversion pair in
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [RawW-1:0]        raw_pressure_i,
  input  logic [RawW-1:0]        raw_temperature_i,
  // compensated pressure out
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] pressure_mbar_o
);

  coeff_t coeff_q;

  // writes beyond the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgC1:   coeff_q.c1 <= cfg_data_i;
        CfgC2:   coeff_q.c2 <= cfg_data_i;
        CfgC3:   coeff_q.c3 <= cfg_data_i;
        CfgC4:   coeff_q.c4 <= cfg_data_i;
        CfgC5:   coeff_q.c5 <= cfg_data_i;
        CfgC6:   coeff_q.c6 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // section handshakes: valid from a register, stall chained back combinationally
  logic fo_valid, fo_stall;
  logic so_valid, so_stall;
  logic pr_valid, pr_stall;
  fo_t  fo;
  so_t  so;
  logic signed [OutW-1:0] p;

  // dT, temperature distance, first-order offset and sensitivity
  psoc_first_order u_first_order (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coeff_i           (coeff_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (fo_valid),
    .out_stall_i       (fo_stall),
    .fo_o              (fo)
  );

  // band squares and second-order corrections
  psoc_second_order u_second_order (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fo_valid),
    .in_stall_o  (fo_stall),
    .fo_i        (fo),
    .out_valid_o (so_valid),
    .out_stall_i (so_stall),
    .so_o        (so)
  );

  // wide sensitivity product as two partial products, then offset and scaling
  psoc_pressure u_pressure (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (so_valid),
    .in_stall_o  (so_stall),
    .so_i        (so),
    .out_valid_o (pr_valid),
    .out_stall_i (pr_stall),
    .p_o         (p)
  );

  // truncating divide by ten; its last stage is the output register
  psoc_div10 u_div10 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pr_valid),
    .in_stall_o  (pr_stall),
    .p_i         (p),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .q_o         (pressure_mbar_o)
  );

  // backpressure on the input only ever comes from a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // without a held result the first section never stalls in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the output side has room");

  // any calibration and any raw pair keep the result well inside 24 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pressure_mbar_o[OutW-1:RawW] == '0)
                  || (pressure_mbar_o[OutW-1:RawW] == '1)))
    else $error("pressure result outside its possible range");

endmodule

/* sim/testbench.sv */
// self-checking testbench for pressure_second_order_compensation_core
// holds a scoreboard class with its own compensation predictor; depends on psoc_pkg and the core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psoc_pkg::*;

  localparam int NumCoeffs   = 6;
  localparam int RawMax      = 24'hFF_FFFF;
  localparam int RefTemp     = 2000;   // 20.00 C, edge of the cool band
  localparam int ColdEdge    = -1500;  // -15.00 C, edge of the cold band
  localparam int NumPhases   = 9;
  localparam int PhaseItems  = 185;
  localparam int DrainCycles = 16;     // pipeline latency plus margin
  localparam int QuietLimit  = 4000;
  localparam int MaxReports  = 10;

  typedef struct {
    logic signed [OutW-1:0] mbar;
    logic [RawW-1:0]        d1;
    logic [RawW-1:0]        d2;
  } pending_mbar_t;

  // scoreboard: mirrors the calibration words and predicts the compensated pressure
  class pressure_scoreboard;
    pending_mbar_t     expected_mbar_q[$];
    logic [CoeffW-1:0] coeff[NumCoeffs];
    int failures;
    int compared;
    int warm_hits;
    int cool_hits;
    int cold_hits;

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      failures  = 0;
      compared  = 0;
      warm_hits = 0;
      cool_hits = 0;
      cold_hits = 0;
    endfunction

    function void write_coeff(int idx, logic [CoeffW-1:0] value);
      coeff[idx] = value;
    endfunction

    // 64-bit signed arithmetic throughout; >>> on longint is an arithmetic shift
    function logic signed [OutW-1:0] compensate_pressure(logic [RawW-1:0] d1,
                                                         logic [RawW-1:0] d2);
      longint dt, temp, off, sens, off2, sens2, dd, ee, p, q;
      dt   = longint'(d2) - longint'(coeff[CfgC5]) * 256;
      temp = ((dt * longint'(coeff[CfgC6])) >>> 23) + RefTemp;
      off  = longint'(coeff[CfgC2]) * 65536 + ((longint'(coeff[CfgC4]) * dt) >>> 7);
      sens = longint'(coeff[CfgC1]) * 32768 + ((longint'(coeff[CfgC3]) * dt) >>> 8);
      dd   = temp - RefTemp;
      if (temp < RefTemp) begin
        off2  = (3 * dd * dd) >>> 1;
        sens2 = (5 * dd * dd) >>> 3;
        if (temp < ColdEdge) begin
          ee    = temp - ColdEdge;
          off2  += 7 * (ee * ee);
          sens2 += 4 * (ee * ee);
          cold_hits++;
        end else begin
          cool_hits++;
        end
      end else begin
        off2  = (dd * dd) >>> 4;
        sens2 = 0;
        warm_hits++;
      end
      p = ((((sens - sens2) * longint'(d1)) >>> 21) - (off - off2)) >>> 13;
      q = p / 10;
      return q[OutW-1:0];
    endfunction

    function void note_conversion(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
      pending_mbar_t item;
      item.mbar = compensate_pressure(d1, d2);
      item.d1   = d1;
      item.d2   = d2;
      expected_mbar_q.push_back(item);
    endfunction

    function void check_pressure(logic signed [OutW-1:0] actual);
      pending_mbar_t want;
      if (expected_mbar_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected pressure result %0d with nothing pending", actual);
        return;
      end
      want = expected_mbar_q.pop_front();
      compared++;
      if (actual !== want.mbar) begin
        failures++;
        if (failures <= MaxReports)
          $display("pressure mismatch: raw p 0x%06h t 0x%06h expected %0d got %0d",
                   want.d1, want.d2, want.mbar, actual);
      end
    endfunction
  endclass

  pressure_scoreboard board;

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   cfg_we_i          = 1'b0;
  logic [2:0]             cfg_index_i       = CfgC1;
  logic [CoeffW-1:0]      cfg_data_i        = '0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_stall_o;
  logic [RawW-1:0]        raw_pressure_i    = '0;
  logic [RawW-1:0]        raw_temperature_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i       = 1'b0;
  logic signed [OutW-1:0] pressure_mbar_o;

  // pacing knobs, percent of cycles
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // calibration words for the coming phase
  logic [CoeffW-1:0] coeff_set [NumCoeffs];
  int settings_loaded = 0;
  int conversions     = 0;

  pressure_second_order_compensation_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pressure_mbar_o   (pressure_mbar_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: values seen at the edge are the pre-edge ones, so a result
  // transaction is checked exactly when the core sees it taken
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
      board.check_pressure(pressure_mbar_o);
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // watchdog: ends the run after too many cycles without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end while (quiet < QuietLimit);
    $display("watchdog: no transaction for %0d cycles", QuietLimit);
    $display("testbench NOT OK");
    $finish;
  end

  // one input transaction, optionally preceded by a random idle gap;
  // valid stays high after acceptance so back-to-back items need no extra step
  task automatic send_conversion(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_conversion(d1, d2);
    conversions++;
  endtask

  // drop valid, wait for every pending result, then let the pipeline run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.expected_mbar_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all six calibration words on consecutive edges
  task automatic load_calibration();
    for (int i = 0; i < NumCoeffs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= coeff_set[i];
      board.write_coeff(i, coeff_set[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // raw temperature that lands the first-order temperature on target (0.01 C),
  // using the smallest dT whose scaled product reaches it; clamped to 24 bits
  function automatic logic [RawW-1:0] raw_temp_for(int target);
    longint num, c6, dt, raw;
    c6 = longint'(coeff_set[CfgC6]);
    if (c6 == 0)
      return RawW'($urandom_range(0, RawMax));
    num = longint'(target - RefTemp) <<< 23;
    dt  = num / c6;
    if (dt * c6 < num)
      dt++;
    raw = dt + longint'(coeff_set[CfgC5]) * 256;
    if (raw < 0)
      raw = 0;
    if (raw > RawMax)
      raw = RawMax;
    return raw[RawW-1:0];
  endfunction

  initial begin : stimulus
    logic [RawW-1:0] p, t;
    int kind, target;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();

      // pacing: none, sender idle, receiver stalling, both
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct    = 80;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct <= 80;
        end
        default: begin
          sender_idle_pct    = 33;
          receiver_stall_pct <= 33;
        end
      endcase

      // calibration: typical part, all ones, all zero, then random words
      // with a bias toward the extremes, and the typical part once more in phase four
      case (phase)
        0, 4: begin
          coeff_set[CfgC1] = 16'd34982;
          coeff_set[CfgC2] = 16'd36352;
          coeff_set[CfgC3] = 16'd20328;
          coeff_set[CfgC4] = 16'd22354;
          coeff_set[CfgC5] = 16'd26646;
          coeff_set[CfgC6] = 16'd26146;
        end
        1: foreach (coeff_set[i]) coeff_set[i] = '1;
        2: foreach (coeff_set[i]) coeff_set[i] = '0;
        default: begin
          foreach (coeff_set[i]) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
              coeff_set[i] = '0;
            else if (kind == 1)
              coeff_set[i] = '1;
            else
              coeff_set[i] = CoeffW'($urandom_range(0, 16'hFFFF));
          end
        end
      endcase
      load_calibration();

      if (phase == 0) begin
        // field extremes and checkerboards
        send_conversion('0, '0);
        send_conversion('1, '1);
        send_conversion('0, '1);
        send_conversion('1, '0);
        send_conversion(24'hAA_AAAA, 24'h55_5555);
        send_conversion(24'h55_5555, 24'hAA_AAAA);
        // zero temperature difference sits exactly on the 20 C edge
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(RefTemp));
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(RefTemp - 1));
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(RefTemp + 1));
        // around the -15 C edge where the extra cold terms kick in
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(ColdEdge));
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(ColdEdge - 1));
        send_conversion(RawW'($urandom_range(0, RawMax)), raw_temp_for(ColdEdge + 1));
        // deep cold with negative shifts everywhere, and a warm point
        send_conversion('1, raw_temp_for(-15000));
        send_conversion('0, raw_temp_for(-15000));
        send_conversion('1, raw_temp_for(6000));
      end else begin
        for (int n = 0; n < PhaseItems; n++) begin
          kind = $urandom_range(0, 9);
          if (kind == 0)
            p = '0;
          else if (kind == 1)
            p = '1;
          else
            p = RawW'($urandom_range(0, RawMax));

          // temperature: half of the items aimed at the two band edges or a wide -250 C to 70 C range
          kind = $urandom_range(0, 9);
          if (kind < 4) begin
            t = RawW'($urandom_range(0, RawMax));
          end else if (kind == 4) begin
            t = $urandom_range(0, 1) ? '1 : '0;
          end else begin
            case ($urandom_range(0, 2))
              0: target = RefTemp - 8 + int'($urandom_range(0, 16));
              1: target = ColdEdge - 8 + int'($urandom_range(0, 16));
              default: target = -25000 + int'($urandom_range(0, 32000));
            endcase
            t = raw_temp_for(target);
          end
          send_conversion(p, t);
        end
      end
    end

    settle();
    if (board.expected_mbar_q.size() != 0)
      $display("%0d expected results never arrived", board.expected_mbar_q.size());

    $display("run: %0d conversions over %0d calibration settings and four pacing modes",
             conversions, settings_loaded);
    $display("bands: warm %0d, cool %0d, cold %0d; %0d results compared, %0d failures",
             board.warm_hits, board.cool_hits, board.cold_hits, board.compared,
             board.failures);
    if (board.failures == 0 && board.expected_mbar_q.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
